// ----- src/cwsch_pkg.sv -----
// ----------------------------------------------------------------------------
// cwsch_pkg
// Shared types and constants of the cooperative thread wake scheduler.
// ----------------------------------------------------------------------------
package cwsch_pkg;

	localparam int THREAD_W   = 6;
	localparam int TIME_W     = 32;
	localparam int OP_W       = 3;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 24;
	// marks examined per scan step
	localparam int MARK_STEP  = 8;
	localparam int MARK_SW    = 3;

	typedef logic [THREAD_W-1:0] thread_t;

	typedef enum logic [OP_W-1:0] {
		OP_YIELD   = 3'd0,
		OP_READY   = 3'd1,
		OP_DELAY   = 3'd2,
		OP_TRIGGER = 3'd3,
		OP_TICK    = 3'd4,
		OP_CLEAR   = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_SHIFT,
		ST_MARKS,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic decode;
		logic scan;
		logic shift;
		logic shift_end;
		logic marks;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic dly_any;
		logic scan_hit;
		logic scan_done;
		logic shift_done;
		logic mark_done;
	} stat_t;

endpackage

// ----- src/cwsch_ram.sv -----
// ----------------------------------------------------------------------------
// cwsch_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cwsch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/cwsch_ctrl.sv -----
// ----------------------------------------------------------------------------
// cwsch_ctrl
// Controller: sequences decode, delay scan, delay close-up, mark scan and the
// output beat; owns both handshakes.
// ----------------------------------------------------------------------------
module cwsch_ctrl
	import cwsch_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	output logic  m_tvalid,
	input  logic  m_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (!stat.is_tick) begin
					state_d = ST_FINISH;
				end else if (stat.dly_any) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_MARKS;
				end
			end
			ST_SCAN: begin
				priority if (stat.scan_hit) begin
					state_d = ST_SHIFT;
				end else if (stat.scan_done) begin
					state_d = ST_MARKS;
				end
			end
			ST_SHIFT: begin
				if (stat.shift_done) begin
					state_d = ST_MARKS;
				end
			end
			ST_MARKS: begin
				if (stat.mark_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && s_tvalid;
		cmd.decode    = (state_q == ST_DECODE);
		cmd.scan      = (state_q == ST_SCAN);
		cmd.shift     = (state_q == ST_SHIFT);
		cmd.shift_end = (state_q == ST_SHIFT) && stat.shift_done;
		cmd.marks     = (state_q == ST_MARKS);
		cmd.emit      = (state_q == ST_FINISH) && out_free;
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- src/cwsch_datapath.sv -----
// ----------------------------------------------------------------------------
// cwsch_datapath
// Datapath: yield FIFO and delay list in RAM, ready and trigger marks,
// elapsed-time compare, mark priority search and the output register.
// ----------------------------------------------------------------------------
module cwsch_datapath
	import cwsch_pkg::*;
#(
	parameter int THREAD_COUNT = 64,
	parameter int YIELD_DEPTH  = 16,
	parameter int DELAY_SLOTS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [OP_W-1:0]       s_tuser,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int YA     = (YIELD_DEPTH > 1) ? $clog2(YIELD_DEPTH) : 1;
	localparam int YCW    = $clog2(YIELD_DEPTH + 1);
	localparam int DA     = (DELAY_SLOTS > 1) ? $clog2(DELAY_SLOTS) : 1;
	localparam int DCW    = $clog2(DELAY_SLOTS + 1);
	localparam int MARKS  = (THREAD_COUNT < (1 << THREAD_W)) ? THREAD_COUNT : (1 << THREAD_W);
	localparam int MW     = (MARKS > 1) ? $clog2(MARKS) : 1;
	localparam int GROUPS = (MARKS + MARK_STEP - 1) / MARK_STEP;
	localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int PADW   = GROUPS * MARK_STEP;
	localparam int DWORD  = THREAD_W + 2 * TIME_W;

	// event registers
	op_t                op_q;
	thread_t            thread_q;
	logic [TIME_W-1:0]  dly_q;
	logic [TIME_W-1:0]  now_q;

	// queue state
	logic [YA-1:0]      yhead_q;
	logic [YCW-1:0]     ycnt_q;
	logic [DCW-1:0]     dcnt_q;
	logic [MARKS-1:0]   ready_q;
	logic [MARKS-1:0]   trig_q;

	// scan state
	logic [DCW-1:0]     idx_q;
	logic [DCW-1:0]     idx_s1;
	logic               pend_s1;
	logic [GW-1:0]      grp_q;

	// result registers
	logic               st_q;
	logic               tv_q;
	thread_t            tt_q;
	logic               cv_q;
	thread_t            ct_q;
	logic               yv_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	// yield FIFO
	logic [YCW:0]       tail_sum;
	logic [YCW:0]       tail;
	logic               y_full;
	logic               y_we;
	logic               y_re;
	thread_t            y_rdata;

	// delay list
	logic               d_full;
	logic               d_we;
	logic [DA-1:0]      d_waddr;
	logic [DWORD-1:0]   d_wdata;
	logic               d_re;
	logic [DWORD-1:0]   d_rdata;
	logic [DCW-1:0]     idx_wr;
	logic [TIME_W-1:0]  elapsed;
	logic               idx_ge;
	logic               hit;

	// marks
	logic [PADW-1:0]      both;
	logic [MARK_STEP-1:0] grp_bits;
	logic [MARK_SW-1:0]   pos;
	logic                 found;
	logic [MW-1:0]        mark_idx;
	logic                 set_ok;

	logic is_yield, is_delay, is_ready, is_trig, is_tick, is_clear;

	assign is_yield = (op_q == OP_YIELD);
	assign is_ready = (op_q == OP_READY);
	assign is_delay = (op_q == OP_DELAY);
	assign is_trig  = (op_q == OP_TRIGGER);
	assign is_tick  = (op_q == OP_TICK);
	assign is_clear = (op_q == OP_CLEAR);

	// yield FIFO: tail is head plus count, wrapped once
	assign tail_sum = (YCW+1)'(yhead_q) + (YCW+1)'(ycnt_q);
	assign tail     = (tail_sum >= (YCW+1)'(YIELD_DEPTH)) ?
		tail_sum - (YCW+1)'(YIELD_DEPTH) : tail_sum;
	assign y_full   = (ycnt_q == YCW'(YIELD_DEPTH));
	assign y_we     = cmd.decode && is_yield && !y_full;
	assign y_re     = cmd.decode && is_tick && (ycnt_q != '0);

	cwsch_ram #(
		.WIDTH (THREAD_W),
		.DEPTH (YIELD_DEPTH)
	) u_yield_ram (
		.clk   (clk),
		.we    (y_we),
		.waddr (tail[YA-1:0]),
		.wdata (thread_q),
		.re    (y_re),
		.raddr (yhead_q),
		.rdata (y_rdata)
	);

	// delay list: word is {owner, length, start}
	assign d_full  = (dcnt_q == DCW'(DELAY_SLOTS));
	assign idx_ge  = (idx_q >= dcnt_q);
	assign d_re    = (cmd.scan || cmd.shift) && !idx_ge;
	assign idx_wr  = idx_s1 - DCW'(1);
	assign elapsed = now_q - d_rdata[TIME_W-1:0];
	assign hit     = cmd.scan && pend_s1 && (elapsed >= d_rdata[2*TIME_W-1:TIME_W]);

	always_comb begin
		if (cmd.shift) begin
			// close up: entry k takes entry k+1
			d_we    = pend_s1;
			d_waddr = idx_wr[DA-1:0];
			d_wdata = d_rdata;
		end else begin
			d_we    = cmd.decode && is_delay && !d_full;
			d_waddr = dcnt_q[DA-1:0];
			d_wdata = {thread_q, dly_q, now_q};
		end
	end

	cwsch_ram #(
		.WIDTH (DWORD),
		.DEPTH (DELAY_SLOTS)
	) u_delay_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.re    (d_re),
		.raddr (idx_q[DA-1:0]),
		.rdata (d_rdata)
	);

	// marks: one group of MARK_STEP per cycle, lowest set bit wins
	assign both     = PADW'(ready_q & trig_q);
	assign grp_bits = both[grp_q*MARK_STEP +: MARK_STEP];
	assign found    = cmd.marks && (grp_bits != '0);
	assign mark_idx = MW'({grp_q, pos});
	assign set_ok   = (32'(thread_q) < THREAD_COUNT);

	always_comb begin
		pos = '0;
		for (int b = MARK_STEP - 1; b >= 0; b--) begin
			if (grp_bits[b]) begin
				pos = MARK_SW'(b);
			end
		end
	end

	assign stat.is_tick    = is_tick;
	assign stat.dly_any    = (dcnt_q != '0);
	assign stat.scan_hit   = hit;
	assign stat.scan_done  = !pend_s1 && idx_ge;
	assign stat.shift_done = !pend_s1 && idx_ge;
	assign stat.mark_done  = found || (grp_q == GW'(GROUPS - 1));

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op_t'(s_tuser);
			thread_q <= s_tdata[THREAD_W-1:0];
			dly_q    <= s_tdata[THREAD_W +: TIME_W];
			now_q    <= s_tdata[THREAD_W+TIME_W +: TIME_W];
		end
		if (d_re && !hit) begin
			idx_s1 <= idx_q;
		end
		if (cmd.emit) begin
			m_tdata_q <= {2'b00, (yv_q ? y_rdata : thread_t'(0)), yv_q,
				ct_q, cv_q, tt_q, tv_q, st_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yhead_q <= '0;
			ycnt_q  <= '0;
			dcnt_q  <= '0;
			ready_q <= '0;
			trig_q  <= '0;
			idx_q   <= '0;
			pend_s1 <= 1'b0;
			grp_q   <= '0;
			st_q    <= 1'b0;
			tv_q    <= 1'b0;
			tt_q    <= '0;
			cv_q    <= 1'b0;
			ct_q    <= '0;
			yv_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				st_q <= 1'b0;
				tv_q <= 1'b0;
				tt_q <= '0;
				cv_q <= 1'b0;
				ct_q <= '0;
				yv_q <= 1'b0;
			end

			if (cmd.decode) begin
				idx_q <= '0;
				grp_q <= '0;
				if (is_yield) begin
					if (y_full) begin
						st_q <= 1'b1;
					end else begin
						ycnt_q <= ycnt_q + YCW'(1);
					end
				end
				if (is_delay) begin
					if (d_full) begin
						st_q <= 1'b1;
					end else begin
						dcnt_q <= dcnt_q + DCW'(1);
					end
				end
				if (is_ready && set_ok) begin
					ready_q[thread_q[MW-1:0]] <= 1'b1;
				end
				if (is_trig && set_ok) begin
					trig_q[thread_q[MW-1:0]] <= 1'b1;
				end
				if (y_re) begin
					yv_q   <= 1'b1;
					ycnt_q <= ycnt_q - YCW'(1);
					yhead_q <= (yhead_q == YA'(YIELD_DEPTH - 1)) ? '0 : yhead_q + YA'(1);
				end
				if (is_clear) begin
					yhead_q <= '0;
					ycnt_q  <= '0;
					dcnt_q  <= '0;
				end
			end else if (hit) begin
				// restart the index just past the expired entry for the close-up
				idx_q <= idx_s1 + DCW'(1);
				tv_q  <= 1'b1;
				tt_q  <= d_rdata[DWORD-1 -: THREAD_W];
			end else if (d_re) begin
				idx_q <= idx_q + DCW'(1);
			end

			pend_s1 <= d_re && !hit;

			if (cmd.shift_end) begin
				dcnt_q <= dcnt_q - DCW'(1);
			end

			if (found) begin
				ready_q[mark_idx] <= 1'b0;
				trig_q[mark_idx]  <= 1'b0;
				cv_q <= 1'b1;
				ct_q <= THREAD_W'({grp_q, pos});
			end else if (cmd.marks) begin
				grp_q <= grp_q + GW'(1);
			end
		end
	end

	assign m_tdata = m_tdata_q;

endmodule

// ----- src/cooperative_thread_wake_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// cooperative_thread_wake_scheduler_top
// Wake scheduler for the threads of a cooperative virtual machine.
// ----------------------------------------------------------------------------
// One event is taken per s-side beat; each event gives exactly one m-side
// beat. Yield, ready, delay, trigger, clear and unused opcodes pass from
// decode straight to the result. A tick runs the delay-list scan through the
// delay RAM, one entry per cycle, which ends early when an expired entry is
// found; then the close-up of the list after removing the expired entry, one
// entry moved per cycle; then the mark search, eight threads per cycle. A
// result held by m-side back-pressure holds back the next result. A new
// event is accepted while the previous result still waits in the output
// register.
module cooperative_thread_wake_scheduler_top
	import cwsch_pkg::*;
#(
	parameter int THREAD_COUNT = 64,
	parameter int YIELD_DEPTH  = 16,
	parameter int DELAY_SLOTS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// thread[5:0], delay_ms[37:6], now_ms[69:38], zero fill
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// opcode[2:0]
	input  logic [OP_W-1:0]       s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// status[0], timer_wake_valid[1], timer_wake_thread[7:2],
	// callback_wake_valid[8], callback_wake_thread[14:9],
	// yield_wake_valid[15], yield_wake_thread[21:16], zero fill
	output logic [OUT_DATA_W-1:0] m_tdata
);

	cmd_t  cmd;
	stat_t stat;

	cwsch_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cwsch_datapath #(
		.THREAD_COUNT (THREAD_COUNT),
		.YIELD_DEPTH  (YIELD_DEPTH),
		.DELAY_SLOTS  (DELAY_SLOTS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata)
	);

endmodule
